>>> src/block_rate_mean_stdev_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the block rate mean / stdev design
// Active in simulation, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BLOCK_RATE_MEAN_STDEV_DEFINES_SVH
`define BLOCK_RATE_MEAN_STDEV_DEFINES_SVH
`ifndef SYNTH
// Property checked on every clock edge outside reset
`define BRMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be true outside reset
`define BRMS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BRMS_ASSERT(lbl, prop, msg)
`define BRMS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> src/brms_pkg.sv
// ----------------------------------------------------------------------------
// brms_pkg
// Widths, types and constants shared by the block rate mean / stdev design.
// ----------------------------------------------------------------------------
`default_nettype none

package brms_pkg;

  localparam int unsigned Channels  = 3;
  localparam int unsigned ChW       = 2;
  localparam int unsigned CountW    = 16;
  localparam int unsigned SumW      = 36;
  localparam int unsigned SqSumW    = 52;
  localparam int unsigned BlockW    = 21;
  localparam int unsigned ScaleW    = 30;
  localparam int unsigned BinW      = 32;
  localparam int unsigned RateW     = 54;
  localparam int unsigned SpreadW   = 53;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned MaxBlock  = 1048576;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  // Working width of the shared arithmetic unit (covers (n*sq - s^2) << 2F)
  localparam int unsigned WideW     = 90;
  localparam int unsigned RootW     = WideW / 2;
  localparam int unsigned RemW      = RootW + 3;
  localparam int unsigned MulW      = SumW;
  localparam int unsigned IterW     = $clog2(WideW + 1);

  localparam int unsigned QueueDepthDef = 2;

  localparam logic [BlockW-1:0] BlockLenReset  = BlockW'(1250);
  localparam logic [ScaleW-1:0] RateScaleReset = ScaleW'(1250000);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_BLOCK_LENGTH = 2'd0,
    REG_RATE_SCALE   = 2'd1
  } reg_idx_e;

  // One closed bin handed from front to back
  typedef struct packed {
    logic [BinW-1:0]                     bin;
    logic [BlockW-1:0]                   n;
    logic [Channels-1:0][SumW-1:0]       sum;
    logic [Channels-1:0][SqSumW-1:0]     sq;
  } bin_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic [BinW-1:0]                     bin_index;
    logic [Channels-1:0][RateW-1:0]      rate;
    logic [Channels-1:0][SpreadW-1:0]    spread;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL_RATE,
    ST_DIV_RATE,
    ST_MUL_NSQ,
    ST_MUL_SS,
    ST_SQRT,
    ST_MUL_SD,
    ST_DIV_SD,
    ST_DONE
  } back_state_e;

endpackage

`default_nettype wire

>>> src/brms_if.sv
// ----------------------------------------------------------------------------
// brms_if
// Valid/ready channels of the block rate mean / stdev design.
// ----------------------------------------------------------------------------
`default_nettype none

// Sample request: one count per channel
interface brms_sample_if;
  logic                         valid;
  logic                         ready;
  logic [brms_pkg::CountW-1:0]  count_0;
  logic [brms_pkg::CountW-1:0]  count_1;
  logic [brms_pkg::CountW-1:0]  count_2;
  modport source (output valid, count_0, count_1, count_2, input ready);
  modport sink   (input valid, count_0, count_1, count_2, output ready);
endinterface

// Result request: one per closed bin
interface brms_result_if;
  logic                          valid;
  logic                          ready;
  logic [brms_pkg::BinW-1:0]     bin_index;
  logic [brms_pkg::RateW-1:0]    rate_0;
  logic [brms_pkg::RateW-1:0]    rate_1;
  logic [brms_pkg::RateW-1:0]    rate_2;
  logic [brms_pkg::SpreadW-1:0]  spread_0;
  logic [brms_pkg::SpreadW-1:0]  spread_1;
  logic [brms_pkg::SpreadW-1:0]  spread_2;
  modport source (output valid, bin_index, rate_0, rate_1, rate_2,
                  spread_0, spread_1, spread_2, input ready);
  modport sink   (input valid, bin_index, rate_0, rate_1, rate_2,
                  spread_0, spread_1, spread_2, output ready);
endinterface

// Register write request
interface brms_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [brms_pkg::CfgIdxW-1:0]   index;
  logic [brms_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/brms_queue.sv
// ----------------------------------------------------------------------------
// brms_queue
// Short FIFO of closed bins between the accumulating front and the math back.
// ----------------------------------------------------------------------------
`default_nettype none

module brms_queue #(
  parameter int unsigned Depth = brms_pkg::QueueDepthDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire brms_pkg::bin_job_t     job_i,
  input  wire logic                   pop_i,
  output brms_pkg::bin_job_t          job_o,
  output brms_pkg::queue_stat_t       stat_o
);
  import brms_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bin_job_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  // pointer and fill bookkeeping
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  assign job_o        = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

>>> src/brms_front.sv
// ----------------------------------------------------------------------------
// brms_front
// Accumulates per-channel sums and sums of squares; closes bins into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module brms_front (
  input  wire logic                                              clk_i,
  input  wire logic                                              rst_ni,
  input  wire logic                                              valid_i,
  output logic                                                   ready_o,
  input  wire logic [brms_pkg::Channels-1:0][brms_pkg::CountW-1:0] counts_i,
  input  wire logic [brms_pkg::BlockW-1:0]                       block_len_i,
  input  wire brms_pkg::queue_stat_t                             qstat_i,
  output logic                                                   push_o,
  output brms_pkg::bin_job_t                                     job_o
);
  import brms_pkg::*;

  logic [Channels-1:0][SumW-1:0]   sum_q, sum_d;
  logic [Channels-1:0][SqSumW-1:0] sq_q, sq_d;
  logic [BlockW-1:0]               cnt_q, cnt_d, cnt_inc, target;
  logic [BinW-1:0]                 bins_q, bins_d;
  logic [2*CountW-1:0]             sqr [Channels];
  logic                            closing, accept;

  // effective block length: zero means one, clamp to the maximum
  always_comb begin
    if (block_len_i == '0) begin
      target = BlockW'(1);
    end else if (block_len_i > BlockW'(MaxBlock)) begin
      target = BlockW'(MaxBlock);
    end else begin
      target = block_len_i;
    end
  end

  assign cnt_inc = cnt_q + BlockW'(1);
  assign closing = (cnt_inc >= target);
  assign ready_o = !qstat_i.full || !closing;
  assign accept  = valid_i && ready_o;

  // per-channel accumulate
  always_comb begin
    for (int c = 0; c < Channels; c++) begin
      sqr[c]   = (2*CountW)'(counts_i[c]) * (2*CountW)'(counts_i[c]);
      sum_d[c] = sum_q[c] + SumW'(counts_i[c]);
      sq_d[c]  = sq_q[c] + SqSumW'(sqr[c]);
    end
    cnt_d  = cnt_inc;
    bins_d = bins_q + BinW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      sq_q   <= '0;
      cnt_q  <= '0;
      bins_q <= '0;
    end else if (accept) begin
      if (closing) begin
        sum_q  <= '0;
        sq_q   <= '0;
        cnt_q  <= '0;
        bins_q <= bins_d;
      end else begin
        sum_q <= sum_d;
        sq_q  <= sq_d;
        cnt_q <= cnt_d;
      end
    end
  end

  // snapshot of the closing bin
  assign push_o    = accept && closing;
  assign job_o.bin = bins_q;
  assign job_o.n   = cnt_inc;
  assign job_o.sum = sum_d;
  assign job_o.sq  = sq_d;

endmodule

`default_nettype wire

>>> src/brms_back.sv
// ----------------------------------------------------------------------------
// brms_back
// Sequencer over one shared shift-add multiplier, restoring divider and
// restoring square root; turns one closed bin into rates and spreads.
// ----------------------------------------------------------------------------
`default_nettype none

module brms_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire brms_pkg::queue_stat_t         qstat_i,
  input  wire brms_pkg::bin_job_t            job_i,
  output logic                               pop_o,
  input  wire logic [brms_pkg::ScaleW-1:0]   scale_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output brms_pkg::result_t                  result_o
);
  import brms_pkg::*;

  back_state_e                     state_q, state_d;
  bin_job_t                        job_q;
  logic [ChW-1:0]                  ch_q;
  logic [WideW-1:0]                acc_q, mc_q, t_q;
  logic [MulW-1:0]                 mp_q;
  logic [BlockW-1:0]               drem_q;
  logic [RemW-1:0]                 srem_q;
  logic [RootW-1:0]                root_q;
  logic [IterW-1:0]                it_q;
  logic [Channels-1:0][RateW-1:0]   rate_q;
  logic [Channels-1:0][SpreadW-1:0] spread_q;
  logic                            out_valid_q;
  result_t                         out_q;
  logic                            load_out, last_ch;

  // divider step
  logic [BlockW:0]                 div_r;
  logic                            div_ge;
  // square root step
  logic [RemW-1:0]                 sq_r, sq_trial;
  logic                            sq_ge;
  // multiplier step
  logic [WideW-1:0]                mul_sum;

  assign div_r    = {drem_q, acc_q[WideW-1]};
  assign div_ge   = (div_r >= {1'b0, job_q.n});
  assign sq_r     = {srem_q[RemW-3:0], acc_q[WideW-1:WideW-2]};
  assign sq_trial = RemW'({root_q, 2'b01});
  assign sq_ge    = (sq_r >= sq_trial);
  assign mul_sum  = mp_q[0] ? (acc_q + mc_q) : acc_q;
  assign last_ch  = (ch_q == ChW'(Channels - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (!qstat_i.empty) state_d = ST_SETUP;
      ST_SETUP:    state_d = ST_MUL_RATE;
      ST_MUL_RATE: if (mp_q == '0) state_d = ST_DIV_RATE;
      ST_DIV_RATE: if (it_q == '0) state_d = ST_MUL_NSQ;
      ST_MUL_NSQ:  if (mp_q == '0) state_d = ST_MUL_SS;
      ST_MUL_SS:   if (mp_q == '0) state_d = ST_SQRT;
      ST_SQRT:     if (it_q == '0) state_d = ST_MUL_SD;
      ST_MUL_SD:   if (mp_q == '0) state_d = ST_DIV_SD;
      ST_DIV_SD:   if (it_q == '0) state_d = last_ch ? ST_DONE : ST_SETUP;
      ST_DONE:     if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o    = (state_q == ST_IDLE) && !qstat_i.empty;
    load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          job_q <= job_i;
          ch_q  <= '0;
        end
      end
      // rate product: sum * scale
      ST_SETUP: begin
        mc_q  <= WideW'(job_q.sum[ch_q]);
        mp_q  <= MulW'(scale_i);
        acc_q <= '0;
      end
      ST_MUL_RATE: begin
        if (mp_q == '0) begin
          acc_q  <= acc_q << FracBits;
          drem_q <= '0;
          it_q   <= IterW'(WideW);
        end else begin
          acc_q <= mul_sum;
          mc_q  <= mc_q << 1;
          mp_q  <= mp_q >> 1;
        end
      end
      ST_DIV_RATE: begin
        if (it_q == '0) begin
          rate_q[ch_q] <= acc_q[RateW-1:0];
          mc_q         <= WideW'(job_q.sq[ch_q]);
          mp_q         <= MulW'(job_q.n);
          acc_q        <= '0;
        end else begin
          drem_q <= div_ge ? BlockW'(div_r - {1'b0, job_q.n}) : div_r[BlockW-1:0];
          acc_q  <= {acc_q[WideW-2:0], div_ge};
          it_q   <= it_q - IterW'(1);
        end
      end
      // n * sum of squares
      ST_MUL_NSQ: begin
        if (mp_q == '0) begin
          t_q   <= acc_q;
          mc_q  <= WideW'(job_q.sum[ch_q]);
          mp_q  <= MulW'(job_q.sum[ch_q]);
          acc_q <= '0;
        end else begin
          acc_q <= mul_sum;
          mc_q  <= mc_q << 1;
          mp_q  <= mp_q >> 1;
        end
      end
      // sum squared, then radicand (n*sq - s^2) << 2F
      ST_MUL_SS: begin
        if (mp_q == '0) begin
          acc_q  <= (t_q - acc_q) << (2 * FracBits);
          srem_q <= '0;
          root_q <= '0;
          it_q   <= IterW'(RootW);
        end else begin
          acc_q <= mul_sum;
          mc_q  <= mc_q << 1;
          mp_q  <= mp_q >> 1;
        end
      end
      // one root bit per cycle
      ST_SQRT: begin
        if (it_q == '0) begin
          mc_q  <= WideW'(root_q);
          mp_q  <= MulW'(scale_i);
          acc_q <= '0;
        end else begin
          srem_q <= sq_ge ? (sq_r - sq_trial) : sq_r;
          root_q <= {root_q[RootW-2:0], sq_ge};
          acc_q  <= acc_q << 2;
          it_q   <= it_q - IterW'(1);
        end
      end
      ST_MUL_SD: begin
        if (mp_q == '0) begin
          drem_q <= '0;
          it_q   <= IterW'(WideW);
        end else begin
          acc_q <= mul_sum;
          mc_q  <= mc_q << 1;
          mp_q  <= mp_q >> 1;
        end
      end
      ST_DIV_SD: begin
        if (it_q == '0) begin
          spread_q[ch_q] <= acc_q[SpreadW-1:0];
          ch_q           <= ch_q + ChW'(1);
        end else begin
          drem_q <= div_ge ? BlockW'(div_r - {1'b0, job_q.n}) : div_r[BlockW-1:0];
          acc_q  <= {acc_q[WideW-2:0], div_ge};
          it_q   <= it_q - IterW'(1);
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_q.bin_index <= job_q.bin;
          out_q.rate      <= rate_q;
          out_q.spread    <= spread_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

`default_nettype wire

>>> src/block_rate_mean_stdev.sv
// ----------------------------------------------------------------------------
// block_rate_mean_stdev
// Block mean rate and standard deviation of three photon-count channels.
//
//   channel | dir | request
//   --------+-----+---------------------------------------------
//   in_i    | in  | one sample: count_0..count_2
//   out_o   | out | one closed bin: bin_index, rate_*, spread_*
//   cfg_i   | in  | register write: index, data (always ready)
//
// Samples are accepted one per cycle; the front stalls only when a bin closes
// and the bin queue is full.
// Per bin the back runs, per channel, two 90-step divides, a 45-step root and
// shift-add multiplies of up to 36 steps.
// Reset clears sums, counters, queue and output valid; no clearing pass.
// The back holds a finished bin in its output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module block_rate_mean_stdev #(
  parameter int unsigned QueueDepth = brms_pkg::QueueDepthDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  brms_sample_if.sink   in_i,
  brms_result_if.source out_o,
  brms_cfg_if.sink      cfg_i
);
  import brms_pkg::*;

`include "block_rate_mean_stdev_defines.svh"

  logic [BlockW-1:0]               block_len_q;
  logic [ScaleW-1:0]               scale_q;
  logic [Channels-1:0][CountW-1:0] counts;
  logic                            push, pop;
  bin_job_t                        push_job, head_job;
  queue_stat_t                     q_stat;
  result_t                         result;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_len_q <= BlockLenReset;
      scale_q     <= RateScaleReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_BLOCK_LENGTH: block_len_q <= cfg_i.data[BlockW-1:0];
        REG_RATE_SCALE:   scale_q     <= cfg_i.data[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  assign counts[0] = in_i.count_0;
  assign counts[1] = in_i.count_1;
  assign counts[2] = in_i.count_2;

  brms_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_i.valid),
    .ready_o     (in_i.ready),
    .counts_i    (counts),
    .block_len_i (block_len_q),
    .qstat_i     (q_stat),
    .push_o      (push),
    .job_o       (push_job)
  );

  brms_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (q_stat)
  );

  brms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (q_stat),
    .job_i       (head_job),
    .pop_o       (pop),
    .scale_i     (scale_q),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .result_o    (result)
  );

  assign out_o.bin_index = result.bin_index;
  assign out_o.rate_0    = result.rate[0];
  assign out_o.rate_1    = result.rate[1];
  assign out_o.rate_2    = result.rate[2];
  assign out_o.spread_0  = result.spread[0];
  assign out_o.spread_1  = result.spread[1];
  assign out_o.spread_2  = result.spread[2];

  // checks
  `BRMS_ASSERT_NEVER(a_queue_overflow, push && q_stat.full, "bin pushed into full queue")
  `BRMS_ASSERT_NEVER(a_queue_underflow, pop && q_stat.empty, "bin popped from empty queue")
  `BRMS_ASSERT(a_single_pop, pop |=> !pop, "back took two bins back to back")

endmodule

`default_nettype wire

>>> bench/block_rate_mean_stdev_test.sv
// ----------------------------------------------------------------------------
// block_rate_mean_stdev_test
// Self-checking bench for the block mean rate / standard deviation unit.
// Samples of three count channels are driven over valid/ready from a queue.
// A local integer model accumulates sums and sums of squares and predicts each
// closed bin (index, mean rates and spreads). A monitor compares every result.
// Block length and rate scale are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
`default_nettype none

module block_rate_mean_stdev_test;
  timeunit 1ns;
  timeprecision 1ps;

  import brms_pkg::*;

  typedef bit [127:0] u128_t;

  typedef struct packed {
    logic [CountW-1:0] c0;
    logic [CountW-1:0] c1;
    logic [CountW-1:0] c2;
  } sample_t;

  localparam int unsigned DrainWait  = 1200;
  localparam int unsigned LongHold   = 3000;
  localparam int unsigned StallLimit = 20000;

  logic clk_i;
  logic rst_ni;

  brms_sample_if sample_bus ();
  brms_result_if result_bus ();
  brms_cfg_if    cfg_bus ();

  block_rate_mean_stdev dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (sample_bus),
    .out_o  (result_bus),
    .cfg_i  (cfg_bus)
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Shared bench state
  sample_t     pending_samples[$];
  result_t     bin_results_q[$];
  int unsigned error_count = 0;
  bit          idle_on     = 1'b1;
  int unsigned hold_ask    = 0;

  // Model state
  bit [63:0]       acc_sum[Channels];
  bit [63:0]       acc_sq[Channels];
  bit [63:0]       acc_samples;
  bit [BinW-1:0]   bins_closed;
  bit [BlockW-1:0] block_len_reg;
  bit [ScaleW-1:0] scale_reg;

  function automatic bit [63:0] int_sqrt(u128_t x);
    bit [63:0] r;
    u128_t     c;
    r = '0;
    for (int b = 49; b >= 0; b--) begin
      c = u128_t'(r) | (u128_t'(1) << b);
      if (c * c <= x) r = c[63:0];
    end
    return r;
  endfunction

  // Add one sample; close the bin when the target count is reached
  function automatic void accumulate_sample(sample_t s);
    bit [63:0] target;
    bit [63:0] v[Channels];
    u128_t     num, dev, root;
    result_t   res;
    v[0] = 64'(s.c0);
    v[1] = 64'(s.c1);
    v[2] = 64'(s.c2);
    target = 64'(block_len_reg);
    if (target == 0) target = 1;
    if (target > 64'(MaxBlock)) target = 64'(MaxBlock);
    for (int c = 0; c < Channels; c++) begin
      acc_sum[c] += v[c];
      acc_sq[c]  += v[c] * v[c];
    end
    acc_samples++;
    if (acc_samples < target) return;
    res = '0;
    res.bin_index = bins_closed;
    for (int c = 0; c < Channels; c++) begin
      num  = (u128_t'(acc_sum[c]) * u128_t'(scale_reg)) << FracBits;
      dev  = u128_t'(acc_samples) * u128_t'(acc_sq[c])
           - u128_t'(acc_sum[c]) * u128_t'(acc_sum[c]);
      root = u128_t'(int_sqrt(dev << (2 * FracBits)));
      res.rate[c]   = RateW'(num / u128_t'(acc_samples));
      res.spread[c] = SpreadW'((root * u128_t'(scale_reg)) / u128_t'(acc_samples));
      acc_sum[c] = '0;
      acc_sq[c]  = '0;
    end
    acc_samples = '0;
    bins_closed = bins_closed + BinW'(1);
    bin_results_q.push_back(res);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [CountW-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return CountW'($urandom);
    if (r == 5) return '0;
    if (r == 6) return '1;
    if (r == 7) return CountW'($urandom_range(0, 15));
    return CountW'($urandom_range(60000, 65535));
  endfunction

  // Sample driver
  int unsigned send_gap;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sample_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (sample_bus.valid && sample_bus.ready)
        accumulate_sample('{sample_bus.count_0, sample_bus.count_1, sample_bus.count_2});
      if (!sample_bus.valid || sample_bus.ready) begin
        if (send_gap > 0) begin
          sample_bus.valid <= 1'b0;
          send_gap--;
        end else if (pending_samples.size() > 0) begin
          sample_t s;
          s = pending_samples.pop_front();
          sample_bus.valid   <= 1'b1;
          sample_bus.count_0 <= s.c0;
          sample_bus.count_1 <= s.c1;
          sample_bus.count_2 <= s.c2;
          send_gap = pick_gap();
        end else begin
          sample_bus.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Result monitor
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned recv_gap  = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (bin_results_q.size() == 0) begin
          $display("%0t unexpected bin result, bin_index %0d", $realtime,
                   result_bus.bin_index);
          error_count++;
        end else begin
          result_t e;
          e = bin_results_q.pop_front();
          check_field("bin_index", e.bin_index, result_bus.bin_index);
          check_field("rate_0",   e.rate[0],   result_bus.rate_0);
          check_field("rate_1",   e.rate[1],   result_bus.rate_1);
          check_field("rate_2",   e.rate[2],   result_bus.rate_2);
          check_field("spread_0", e.spread[0], result_bus.spread_0);
          check_field("spread_1", e.spread[1], result_bus.spread_1);
          check_field("spread_2", e.spread[2], result_bus.spread_2);
        end
      end
      if (hold_seen != hold_ask) begin
        hold_seen = hold_ask;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // Watchdog on cycles with no request moving
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready) || !rst_ni) begin
      quiet_cycles = 0;
    end else if (++quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    if (idx == REG_BLOCK_LENGTH) block_len_reg = value[BlockW-1:0];
    else if (idx == REG_RATE_SCALE) scale_reg = value[ScaleW-1:0];
    cfg_bus.valid <= 1'b0;
  endtask

  // Wait until all samples are taken and every bin has been checked
  task automatic drain();
    while (pending_samples.size() > 0 || sample_bus.valid || bin_results_q.size() > 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic push_sample(logic [CountW-1:0] a, logic [CountW-1:0] b,
                             logic [CountW-1:0] c);
    pending_samples.push_back('{a, b, c});
  endtask

  task automatic push_random(int unsigned count);
    repeat (count) push_sample(pick_count(), pick_count(), pick_count());
  endtask

  // Upper data bits beyond the register width are random; they are dropped
  task automatic set_block(logic [BlockW-1:0] len);
    write_reg(REG_BLOCK_LENGTH, {(CfgDataW-BlockW)'($urandom), len});
  endtask

  task automatic set_scale(logic [ScaleW-1:0] sc);
    write_reg(REG_RATE_SCALE, {2'($urandom), sc});
  endtask

  // Stimulus
  initial begin
    int unsigned remaining;
    int unsigned chunk;
    int unsigned r;
    sample_bus.valid   = 1'b0;
    sample_bus.count_0 = '0;
    sample_bus.count_1 = '0;
    sample_bus.count_2 = '0;
    result_bus.ready   = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = REG_BLOCK_LENGTH;
    cfg_bus.data       = '0;
    for (int c = 0; c < Channels; c++) begin
      acc_sum[c] = '0;
      acc_sq[c]  = '0;
    end
    acc_samples   = '0;
    bins_closed   = '0;
    block_len_reg = BlockLenReset;
    scale_reg     = RateScaleReset;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (3) @(posedge clk_i);

    // Reset config, partial block, then zero length closes it on the next sample
    push_sample('1, '0, 16'hAAAA);
    push_sample('0, '1, 16'h5555);
    push_sample(16'h1234, 16'h8000, 16'h0001);
    drain();
    set_block('0);
    push_sample('1, '1, '1);
    push_sample('0, '0, '0);
    drain();

    // Block of two at full scale: largest spread
    set_block(2);
    set_scale(1000000000);
    push_sample('1, '0, '1);
    push_sample('0, '1, '1);
    push_sample('1, '1, '0);
    push_sample('0, '0, '0);
    drain();

    // Register width maximum on the scale, zero scale
    set_scale('1);
    push_sample('1, '0, 16'hAAAA);
    push_sample('0, '1, 16'h5555);
    drain();
    set_scale('0);
    push_sample('1, 16'h00FF, 16'hFF00);
    push_sample(16'h0F0F, '1, 16'hF0F0);
    drain();

    // Oversized lengths saturate; then lowered mid-block
    set_scale(1);
    set_block(BlockW'(MaxBlock));
    push_sample('1, '1, '1);
    push_sample('0, 16'h7FFF, '0);
    drain();
    set_block('1);
    push_sample(16'h8001, '0, '1);
    push_sample('1, '0, 16'h0002);
    drain();
    set_block(1);
    push_sample('1, '1, '1);
    drain();

    // Long receiver stall with back-to-back single-sample bins
    idle_on = 1'b0;
    set_scale(1250000);
    hold_ask++;
    push_random(12);
    drain();
    idle_on = 1'b1;

    // Random phases, mostly short blocks
    remaining = 620;
    while (remaining > 0) begin
      r = $urandom_range(0, 19);
      if (r == 0) set_block('0);
      else if (r < 4) set_block(1);
      else set_block(BlockW'($urandom_range(2, 10)));
      r = $urandom_range(0, 19);
      if (r == 0) set_scale('0);
      else if (r == 1) set_scale(1);
      else if (r == 2) set_scale(1000000000);
      else if (r == 3) set_scale('1);
      else set_scale(ScaleW'($urandom_range(1, 1000000000)));
      idle_on = ($urandom_range(0, 3) != 0);
      chunk = $urandom_range(25, 60);
      if (chunk > remaining) chunk = remaining;
      push_random(chunk);
      remaining -= chunk;
      drain();
    end

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+src
src/brms_pkg.sv
src/brms_if.sv
src/brms_queue.sv
src/brms_front.sv
src/brms_back.sv
src/block_rate_mean_stdev.sv
bench/block_rate_mean_stdev_test.sv
